@@ sv/pse_pkg.sv @@
// shared constants, command and status codes, and sequencer state type
`default_nettype none
package pse_pkg;
    // operand stack size and derived widths
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // payload widths
    localparam int CMD_W  = 3;
    localparam int STAT_W = 3;
    localparam int Q_W    = 32;
    localparam int INT_W  = 16;

    // iteration counts of the shared add/subtract unit
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 48;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_UNDER = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DIV0  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd4;

    // q16.16 saturation limits
    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_FIX,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

@@ sv/pse_if.sv @@
// command and result channel interfaces
`default_nettype none
interface pse_cmd_if;
    import pse_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [Q_W-1:0]   operand_value;

    modport source (output valid, cmd, operand_value, input ready);
    modport sink   (input valid, cmd, operand_value, output ready);
endinterface

interface pse_res_if;
    import pse_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [Q_W-1:0]   top_value;
    logic signed [INT_W-1:0] result_int;
    logic [CNT_W-1:0]        stack_depth;

    modport source (output valid, status, top_value, result_int, stack_depth, input ready);
    modport sink   (input valid, status, top_value, result_int, stack_depth, output ready);
endinterface
`default_nettype wire

@@ sv/postfix_stack_evaluator_top.sv @@
// postfix evaluator: operand stack in ram, sequencer and one shared add/subtract unit
//
// usage: items arrive on i_cmd (cmd, operand_value) with a valid/ready handshake
// and each item yields exactly one result item on o_res (status, top_value,
// result_int, stack_depth). one item is worked on at a time; i_cmd.ready is
// high only while the sequencer is idle.
// path from acceptance to o_res.valid: push, read, clear, errors and unused
// codes go straight to the done state; add and subtract pass through load
// first; multiply runs load, 32 shift-add passes and fix; divide runs load,
// 48 restoring shift-subtract passes and fix, all on the shared 34-bit adder.
// the next item is taken in the cycle after the result is loaded.
// the result sits in an output register; when the receiver stalls, the
// finished item waits there and the following item still runs up to its own
// result, which then waits until the output register frees up.
// reset (i_rst_n low, synchronous) empties the stack and drops any pending
// result; stack contents are not cleared, only the entry count.
`default_nettype none
module postfix_stack_evaluator_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pse_cmd_if.sink   i_cmd,
    pse_res_if.source o_res
);
    import pse_pkg::*;

    // sequencer and stack control registers
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [Q_W-1:0]          r_top, n_top;
    logic [STAT_W-1:0]       r_status, n_status;
    logic [INT_W-1:0]        r_rint, n_rint;
    logic [CMD_W-1:0]        r_op, n_op;
    logic                    r_neg, n_neg;
    logic [32:0]             r_hi, n_hi;
    logic [47:0]             r_lo, n_lo;
    logic [31:0]             r_dvs, n_dvs;
    logic [STEP_W-1:0]       r_step, n_step;

    // output register
    logic                    r_ovld;
    logic [STAT_W-1:0]       r_ostat;
    logic [Q_W-1:0]          r_otop;
    logic [INT_W-1:0]        r_oint;
    logic [CNT_W-1:0]        r_odep;
    logic                    w_oload;

    // ram signals
    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic [Q_W-1:0]          w_wdata;
    logic [ADDR_W-1:0]       w_raddr;
    logic [Q_W-1:0]          w_rdata;
    logic [CNT_W-1:0]        w_cnt_m2;

    // shared adder
    logic [33:0]             u_x, u_y, u_sum;
    logic                    u_sub;

    // helpers
    logic                    w_accept;
    logic [32:0]             w_rs;
    logic [32:0]             w_mac;
    logic [Q_W-1:0]          w_abs_a, w_abs_b;
    logic [47:0]             w_mag;
    logic [Q_W-1:0]          w_fix;
    logic [Q_W-1:0]          w_addsat;
    logic [INT_W-1:0]        w_trunc;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    // second entry from the top sits at count minus two
    assign w_cnt_m2 = r_cnt - CNT_W'(2);
    assign w_raddr  = w_cnt_m2[ADDR_W-1:0];

    pse_ram #(
        .WIDTH (Q_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared adder operand selection
    assign w_rs = {r_hi[31:0], r_lo[47]};
    always_comb begin
        u_x   = {{2{w_rdata[31]}}, w_rdata};
        u_y   = {{2{r_top[31]}}, r_top};
        u_sub = (r_op == CMD_SUB);
        unique case (r_state)
            S_MUL: begin
                u_x   = {1'b0, r_hi};
                u_y   = {2'b00, r_dvs};
                u_sub = 1'b0;
            end
            S_DIV: begin
                u_x   = {1'b0, w_rs};
                u_y   = {2'b00, r_dvs};
                u_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end
    assign u_sum = u_x + (u_sub ? ~u_y : u_y) + {33'd0, u_sub};

    // add/subtract saturation: sum fits 33 bits, overflow when bits 32 and 31 differ
    assign w_addsat = (u_sum[32] != u_sum[31]) ? (u_sum[32] ? Q_MIN : Q_MAX) : u_sum[31:0];

    // multiply accumulate select
    assign w_mac = r_lo[0] ? u_sum[32:0] : r_hi;

    // operand magnitudes: b from ram, a is the cached top
    assign w_abs_a = r_top[31] ? (~r_top + 32'd1) : r_top;
    assign w_abs_b = w_rdata[31] ? (~w_rdata + 32'd1) : w_rdata;

    // magnitude of the scaled result, then sign and saturation
    assign w_mag = (r_op == CMD_MUL) ? {r_hi[31:0], r_lo[31:16]} : r_lo;
    always_comb begin
        if (r_neg) begin
            w_fix = (w_mag > 48'h0000_8000_0000) ? Q_MIN : (~w_mag[31:0] + 32'd1);
        end else begin
            w_fix = (w_mag > 48'h0000_7FFF_FFFF) ? Q_MAX : w_mag[31:0];
        end
    end

    // top truncated toward zero to an integer
    assign w_trunc = r_top[31:16] + {15'd0, r_top[31] && (r_top[15:0] != 16'd0)};

    // next state and datapath control
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_top    = r_top;
        n_status = r_status;
        n_rint   = r_rint;
        n_op     = r_op;
        n_neg    = r_neg;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_dvs    = r_dvs;
        n_step   = r_step;
        w_we     = 1'b0;
        w_waddr  = w_raddr;
        w_wdata  = i_cmd.operand_value;
        w_oload  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = STAT_OK;
                    n_rint   = '0;
                    n_op     = i_cmd.cmd;
                    n_state  = S_DONE;
                    case (i_cmd.cmd) inside
                        CMD_PUSH: begin
                            if (r_cnt >= CNT_W'(STACK_DEPTH)) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_cnt[ADDR_W-1:0];
                                n_top   = i_cmd.operand_value;
                                n_cnt   = r_cnt + CNT_W'(1);
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                            if (r_cnt < CNT_W'(2)) begin
                                n_status = STAT_UNDER;
                                n_cnt    = '0;
                                n_top    = '0;
                            end else if (i_cmd.cmd == CMD_DIV && r_top == '0) begin
                                n_status = STAT_DIV0;
                                n_cnt    = '0;
                                n_top    = '0;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        CMD_READ: begin
                            if (r_cnt == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_rint = w_trunc;
                            end
                        end
                        CMD_CLEAR: begin
                            n_cnt = '0;
                            n_top = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                // second operand is on the ram read port now
                n_neg = w_rdata[31] ^ r_top[31];
                n_hi  = '0;
                if (r_op == CMD_MUL) begin
                    n_lo    = {16'd0, w_abs_a};
                    n_dvs   = w_abs_b;
                    n_step  = STEP_W'(MUL_STEPS - 1);
                    n_state = S_MUL;
                end else if (r_op == CMD_DIV) begin
                    n_lo    = {w_abs_b, 16'd0};
                    n_dvs   = w_abs_a;
                    n_step  = STEP_W'(DIV_STEPS - 1);
                    n_state = S_DIV;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = w_addsat;
                    n_top   = w_addsat;
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                // one shift-add pass per cycle
                n_hi   = {1'b0, w_mac[32:1]};
                n_lo   = {16'd0, w_mac[0], r_lo[31:1]};
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = S_FIX;
                end
            end
            S_DIV: begin
                // one restoring shift-subtract pass per cycle
                n_hi   = u_sum[33] ? w_rs : u_sum[32:0];
                n_lo   = {r_lo[46:0], ~u_sum[33]};
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                w_we    = 1'b1;
                w_wdata = w_fix;
                n_top   = w_fix;
                n_cnt   = r_cnt - CNT_W'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovld || o_res.ready) begin
                    w_oload = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_top   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_top   <= n_top;
            if (w_oload) begin
                r_ovld <= 1'b1;
            end else if (o_res.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rint   <= n_rint;
        r_op     <= n_op;
        r_neg    <= n_neg;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_dvs    <= n_dvs;
        r_step   <= n_step;
        if (w_oload) begin
            r_ostat <= r_status;
            r_otop  <= r_top;
            r_oint  <= r_rint;
            r_odep  <= r_cnt;
        end
    end

    assign o_res.valid       = r_ovld;
    assign o_res.status      = r_ostat;
    assign o_res.top_value   = r_otop;
    assign o_res.result_int  = r_oint;
    assign o_res.stack_depth = r_odep;
endmodule
`default_nettype wire

@@ sv/pse_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ sv/pse_chk.sv @@
// port-level checker for the postfix evaluator, bound to the top level
`default_nettype none
module pse_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [pse_pkg::STAT_W-1:0]    i_status,
    input  logic [pse_pkg::Q_W-1:0]       i_top,
    input  logic [pse_pkg::INT_W-1:0]     i_rint,
    input  logic [pse_pkg::CNT_W-1:0]     i_depth
);
    import pse_pkg::*;

    // depth never exceeds the stack size
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_depth <= CNT_W'(STACK_DEPTH))
        else $error("stack depth beyond stack size");

    // an empty stack shows a zero top
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_depth == '0 |-> i_top == '0)
        else $error("nonzero top on empty stack");

    // underflow and divide by zero leave the stack empty
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == STAT_UNDER || i_status == STAT_DIV0)
        |-> i_depth == '0)
        else $error("stack not emptied on error");

    // a full-stack push reports a full stack and a zero integer result
    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STAT_FULL |-> i_depth == CNT_W'(STACK_DEPTH)
        && i_rint == '0)
        else $error("full status with stack not full");

    // a stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_top)
        && $stable(i_depth) && $stable(i_status))
        else $error("result item changed while stalled");
endmodule

bind postfix_stack_evaluator_top pse_chk u_pse_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_top       (o_res.top_value),
    .i_rint      (o_res.result_int),
    .i_depth     (o_res.stack_depth)
);
`default_nettype wire
